// ===== src/bai_pkg.sv =====
// Shared types, codes and sizes for the bounded array list.
package bai_pkg;

    localparam int CAP   = 16;
    localparam int IDXW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNTW  = $clog2(CAP + 1);
    localparam int POSW  = 5;
    localparam int CMDW  = 3;
    localparam int WORDW = 32;
    localparam int STATW = 2;
    localparam int CMPW  = (CNTW > POSW) ? CNTW : POSW;

    localparam int S_DATAW = 40;
    localparam int M_DATAW = 48;

    typedef logic signed [WORDW-1:0] t_word;

    typedef enum logic [CMDW-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_OVERWRITE = 3'd2,
        CMD_DELETE    = 3'd3,
        CMD_SEARCH    = 3'd4,
        CMD_READ      = 3'd5
    } t_cmd;

    typedef enum logic [STATW-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POSW-1:0]   pos;
        logic [CNTW-1:0]   count;
        t_word             val;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH
    } t_state;

endpackage

// ===== src/bai_cell.sv =====
// One list slot: holds a word, shifts from either neighbour, compares with the key.
module bai_cell (
    input  logic                     i_clk,
    input  logic [bai_pkg::IDXW-1:0] i_idx,
    input  bai_pkg::t_cell_ctl       i_ctl,
    input  bai_pkg::t_word           i_below,
    input  bai_pkg::t_word           i_above,
    output bai_pkg::t_word           o_data,
    output logic                     o_match
);

    bai_pkg::t_word                r_data;
    bai_pkg::t_word                n_data;
    logic [bai_pkg::CMPW-1:0]      w_idx;
    logic [bai_pkg::CMPW-1:0]      w_pos;
    logic [bai_pkg::CMPW-1:0]      w_cnt;

    assign w_idx = bai_pkg::CMPW'(i_idx);
    assign w_pos = bai_pkg::CMPW'(i_ctl.pos);
    assign w_cnt = bai_pkg::CMPW'(i_ctl.count);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            bai_pkg::CELL_INSERT: begin
                if (w_idx > w_pos) begin
                    n_data = i_below;
                end else if (w_idx == w_pos) begin
                    n_data = i_ctl.val;
                end
            end
            bai_pkg::CELL_DELETE: begin
                if (w_idx >= w_pos) begin
                    n_data = i_above;
                end
            end
            bai_pkg::CELL_WRITE: begin
                if (w_idx == w_pos) begin
                    n_data = i_ctl.val;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    // only live slots take part in a search
    assign o_match = (r_data == i_ctl.val) && (w_idx < w_cnt);

endmodule

// ===== src/bai_chain.sv =====
// Row of list slots wired to their neighbours, with match vector and read select.
module bai_chain (
    input  logic                     i_clk,
    input  bai_pkg::t_cell_ctl       i_ctl,
    input  logic [bai_pkg::IDXW-1:0] i_rd_idx,
    output bai_pkg::t_word           o_rd_data,
    output logic [bai_pkg::CAP-1:0]  o_hits
);

    bai_pkg::t_word w_data [bai_pkg::CAP];

    for (genvar g = 0; g < bai_pkg::CAP; g++) begin : g_cell
        bai_pkg::t_word w_below;
        bai_pkg::t_word w_above;

        if (g == 0) begin : g_first
            assign w_below = w_data[g];
        end else begin : g_mid_lo
            assign w_below = w_data[g-1];
        end

        // top slot has nothing above it; what it loads there lies past the new length
        if (g == bai_pkg::CAP - 1) begin : g_last
            assign w_above = w_data[g];
        end else begin : g_mid_hi
            assign w_above = w_data[g+1];
        end

        bai_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (bai_pkg::IDXW'(g)),
            .i_ctl   (i_ctl),
            .i_below (w_below),
            .i_above (w_above),
            .o_data  (w_data[g]),
            .o_match (o_hits[g])
        );
    end

    assign o_rd_data = w_data[i_rd_idx];

endmodule

// ===== src/bounded_array_insert_delete.sv =====
// Top level of the bounded array list: command sequencer, slot row and output register.
//
//  channel | dir | tdata fields (low bit up)                          | tlast
//  s       | in  | command[2:0] position[7:3] value[39:8]             | -
//  m       | out | status[1:0] found_position[6:2] read_value[38:7]   | last
//          |     | length[43:39], zero fill [47:44]                   |
//
// A command is taken in the idle state and carried out in the execute state; insert and
// delete move every slot at or above the position in one step through the neighbour
// links. A search that finds matches then moves on to the search state, which sends
// one match per transfer from the single output register, the last with tlast set.
// Reset clears the length and the control state; slot contents are left as they are.
// The execute step waits while the output register holds an untaken transfer.
module bounded_array_insert_delete (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bai_pkg::S_DATAW-1:0]  i_s_tdata,  // command, position, value
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bai_pkg::M_DATAW-1:0]  o_m_tdata,  // status, found_position,
                                                     // read_value, length, zero fill
    output logic                         o_m_tlast
);

    bai_pkg::t_state                 r_state, n_state;
    logic [bai_pkg::CNTW-1:0]        r_count, n_count;
    logic [bai_pkg::CMDW-1:0]        r_cmd;
    logic [bai_pkg::POSW-1:0]        r_pos;
    bai_pkg::t_word                  r_val;
    logic [bai_pkg::CAP-1:0]         r_hits, n_hits;

    logic                            r_ovalid, n_ovalid;
    bai_pkg::t_status                r_ostat, n_ostat;
    logic [bai_pkg::POSW-1:0]        r_ofpos, n_ofpos;
    bai_pkg::t_word                  r_orval, n_orval;
    logic [bai_pkg::CNTW-1:0]        r_olen, n_olen;
    logic                            r_olast, n_olast;

    bai_pkg::t_cell_ctl              w_ctl;
    bai_pkg::t_word                  w_rd_data;
    logic [bai_pkg::CAP-1:0]         w_hits;
    logic [bai_pkg::CAP-1:0]         w_rest;
    logic [bai_pkg::POSW-1:0]        w_low;
    logic                            w_out_free;
    logic                            w_accept;
    logic [bai_pkg::CMPW-1:0]        w_pos_c;
    logic [bai_pkg::CMPW-1:0]        w_cnt_c;
    logic [bai_pkg::CMPW-1:0]        w_cap_c;

    assign o_s_tready = (r_state == bai_pkg::ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;

    assign w_pos_c = bai_pkg::CMPW'(r_pos);
    assign w_cnt_c = bai_pkg::CMPW'(r_count);
    assign w_cap_c = bai_pkg::CMPW'(bai_pkg::CAP);

    bai_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_idx  (bai_pkg::IDXW'(r_pos)),
        .o_rd_data (w_rd_data),
        .o_hits    (w_hits)
    );

    // lowest pending match and what remains after it
    always_comb begin
        w_low = '0;
        for (int i = bai_pkg::CAP - 1; i >= 0; i--) begin
            if (r_hits[i]) begin
                w_low = bai_pkg::POSW'(i);
            end
        end
        w_rest = r_hits & (r_hits - bai_pkg::CAP'(1));
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hits    = r_hits;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_ostat   = r_ostat;
        n_ofpos   = r_ofpos;
        n_orval   = r_orval;
        n_olen    = r_olen;
        n_olast   = r_olast;
        w_ctl.op    = bai_pkg::CELL_HOLD;
        w_ctl.pos   = r_pos;
        w_ctl.count = r_count;
        w_ctl.val   = r_val;

        case (r_state)
            bai_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = bai_pkg::ST_EXEC;
                end
            end
            bai_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    n_state  = bai_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                    n_ostat  = bai_pkg::STAT_OK;
                    n_ofpos  = '0;
                    n_orval  = '0;
                    n_olast  = 1'b1;
                    case (r_cmd)
                        bai_pkg::CMD_APPEND: begin
                            if (w_cnt_c >= w_cap_c) begin
                                n_ostat = bai_pkg::STAT_OVERFLOW;
                            end else begin
                                w_ctl.op  = bai_pkg::CELL_WRITE;
                                w_ctl.pos = bai_pkg::POSW'(r_count);
                                n_count   = r_count + bai_pkg::CNTW'(1);
                            end
                        end
                        bai_pkg::CMD_INSERT: begin
                            if (w_pos_c > w_cnt_c) begin
                                n_ostat = bai_pkg::STAT_BAD_INDEX;
                            end else if (w_cnt_c >= w_cap_c) begin
                                n_ostat = bai_pkg::STAT_OVERFLOW;
                            end else begin
                                w_ctl.op = bai_pkg::CELL_INSERT;
                                n_count  = r_count + bai_pkg::CNTW'(1);
                            end
                        end
                        bai_pkg::CMD_OVERWRITE: begin
                            if (w_pos_c >= w_cnt_c) begin
                                n_ostat = bai_pkg::STAT_BAD_INDEX;
                            end else begin
                                w_ctl.op = bai_pkg::CELL_WRITE;
                            end
                        end
                        bai_pkg::CMD_DELETE: begin
                            if (w_pos_c >= w_cnt_c) begin
                                n_ostat = bai_pkg::STAT_BAD_INDEX;
                            end else begin
                                w_ctl.op = bai_pkg::CELL_DELETE;
                                n_count  = r_count - bai_pkg::CNTW'(1);
                            end
                        end
                        bai_pkg::CMD_SEARCH: begin
                            if (w_hits == '0) begin
                                n_ostat = bai_pkg::STAT_NOT_FOUND;
                            end else begin
                                // matches go out one per cycle from the search state while the output register is free
                                n_ovalid = 1'b0;
                                n_hits   = w_hits;
                                n_state  = bai_pkg::ST_SRCH;
                            end
                        end
                        bai_pkg::CMD_READ: begin
                            if (w_pos_c >= w_cnt_c) begin
                                n_ostat = bai_pkg::STAT_BAD_INDEX;
                            end else begin
                                n_orval = w_rd_data;
                            end
                        end
                        default: begin
                            n_ostat = bai_pkg::STAT_OK;
                        end
                    endcase
                    n_olen = n_count;
                end
            end
            bai_pkg::ST_SRCH: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = bai_pkg::STAT_OK;
                    n_ofpos  = w_low;
                    n_orval  = '0;
                    n_olen   = r_count;
                    n_olast  = (w_rest == '0);
                    n_hits   = w_rest;
                    if (w_rest == '0) begin
                        n_state = bai_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = bai_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bai_pkg::ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_tdata[2:0];
            r_pos <= i_s_tdata[7:3];
            r_val <= i_s_tdata[39:8];
        end
        r_hits  <= n_hits;
        r_ostat <= n_ostat;
        r_ofpos <= n_ofpos;
        r_orval <= n_orval;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {4'b0000, r_olen, r_orval, r_ofpos, r_ostat};

endmodule
